>>> rtl/gmsf_pkg.sv
package gmsf_pkg;

  localparam int unsigned IdxW     = 16;
  localparam int unsigned GapW     = 16;
  localparam int unsigned OqDepth  = 8;
  localparam int unsigned OqAw     = $clog2(OqDepth);
  localparam int unsigned OqCw     = $clog2(OqDepth + 1);
  localparam int unsigned MaxRes   = 3;

  typedef struct packed {
    logic sample_valid;
    logic series_last;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0] row_index;
    logic            marginal_flag;
    logic            run_last;
  } out_beat_t;

  // Working copy of the pending-row queue and of the results built for one beat.
  typedef struct packed {
    logic [IdxW-1:0] idx0;
    logic [IdxW-1:0] idx1;
    logic            flg0;
    logic            flg1;
    logic [1:0]      cnt;
    logic [1:0]      n;
    out_beat_t [MaxRes-1:0] res;
  } work_t;

  function automatic work_t emit_one(work_t w, logic [IdxW-1:0] idx, logic flag);
    work_t r;
    r = w;
    if (r.n != 2'd3) begin
      r.res[r.n] = '{row_index: idx, marginal_flag: flag, run_last: 1'b0};
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

  function automatic work_t emit_front(work_t w);
    work_t r;
    r = w;
    if (r.cnt != 2'd0) begin
      r = emit_one(r, r.idx0, r.flg0);
      r.idx0 = r.idx1;
      r.flg0 = r.flg1;
      r.cnt = r.cnt - 2'd1;
    end
    return r;
  endfunction

  function automatic work_t emit_all(work_t w);
    work_t r;
    r = w;
    if (r.cnt != 2'd0) begin
      r = emit_one(r, r.idx0, r.flg0);
    end
    if (r.cnt == 2'd2) begin
      r = emit_one(r, r.idx1, r.flg1);
    end
    r.cnt = 2'd0;
    return r;
  endfunction

  function automatic work_t mark_newest(work_t w);
    work_t r;
    r = w;
    if (r.cnt == 2'd2) begin
      r.flg1 = 1'b1;
    end else if (r.cnt == 2'd1) begin
      r.flg0 = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/gap_marginal_sample_flagger_top.sv
// Marginal sample flagger for a series of validity bits.
// Input channel: one beat per row (sample_valid, series_last) on in_valid/in_stall.
// Output channel: one beat per decided row (row_index, marginal_flag, run_last)
// on out_valid/out_stall. Every row yields exactly one output beat; run_last
// marks the last output beat caused by a given input beat.
// Configuration: cfg_we writes cfg_wdata into the gap window (reset value 3);
// write it only while the block is idle.
// Throughput: one input beat per cycle while in_stall is low. All decisions
// for a beat are made in the cycle it is accepted, and its zero to three
// results enter an 8-entry output queue; in_stall rises when fewer than
// three free entries remain, so the sustained rate is set by the output side
// draining one beat per cycle. An invalid row is queued when accepted. A
// valid row is held (at most two at a time) until a later row or the end
// of the series decides its flag, and then enters the output queue with that
// beat. Reset clears the series state, the held rows and the output queue
// and sets the gap window to 3. When the receiver stalls, out_data holds
// its beat and the queue fills until in_stall pushes back on the sender.
module gap_marginal_sample_flagger_top #(
  parameter int unsigned MAX_ROWS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gmsf_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gmsf_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import gmsf_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROWS);

  logic [GapW-1:0] gap_r;
  logic [CntW-1:0] row_cnt_r, row_cnt_nxt;
  logic [GapW-1:0] run_r, run_nxt;
  logic [2:0]      hist_r, hist_nxt;
  logic [1:0]      seen_r, seen_nxt;
  logic [IdxW-1:0] pidx_r [2];
  logic [1:0]      pflg_r, pflg_nxt;
  logic [1:0]      pcnt_r;

  out_beat_t       oq_mem [OqDepth];
  logic [OqAw-1:0] oq_wr_r, oq_rd_r;
  logic [OqCw-1:0] oq_cnt_r;

  logic            in_acc;
  logic            out_acc;
  logic [31:0]     row_ext;
  logic [IdxW-1:0] cur_idx;
  logic            v, last, p1, p2, p3, long_run;
  logic [GapW-1:0] run_w;
  work_t           w;
  logic [1:0]      push_n;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign row_ext = 32'(row_cnt_r);
  assign cur_idx = row_ext[IdxW-1:0];
  assign v       = in_data.sample_valid;
  assign last    = in_data.series_last;
  assign p1      = hist_r[0];
  assign p2      = hist_r[1];
  assign p3      = hist_r[2];

  always_comb begin
    w        = '0;
    w.idx0   = pidx_r[0];
    w.idx1   = pidx_r[1];
    w.flg0   = pflg_r[0];
    w.flg1   = pflg_r[1];
    w.cnt    = pcnt_r;
    run_w    = run_r;
    long_run = 1'b0;

    if (!v) begin
      if (p1) begin
        if (!p2) begin
          // A lone valid row just ended; it needs a row on its left.
          if (seen_r >= 2'd2) begin
            w = mark_newest(w);
            w = emit_all(w);
          end
        end else if (!p3) begin
          // A valid pair just ended.
          if (seen_r == 2'd3) begin
            if (w.cnt != 2'd0) w.flg0 = 1'b1;
            if (w.cnt == 2'd2) w.flg1 = 1'b1;
            w = emit_all(w);
          end else if (w.cnt == 2'd2) begin
            w = emit_front(w);
          end
        end
        run_w = GapW'(1);
      end else if (run_w != '1) begin
        run_w = run_w + GapW'(1);
      end
      w = emit_one(w, cur_idx, 1'b0);
      long_run = run_w >= gap_r;
      if (w.cnt != 2'd0 && long_run) begin
        w = mark_newest(w);
        w = emit_all(w);
      end
    end else begin
      if (!p1) begin
        if (w.cnt != 2'd0) begin
          if (run_w >= gap_r) w = mark_newest(w);
          w = emit_all(w);
        end
      end else begin
        if (gap_r == '0) w = mark_newest(w);
        if (p2) w = emit_all(w);
      end
      if (w.cnt == 2'd2) w = emit_front(w);
      if (w.cnt == 2'd0) begin
        w.idx0 = cur_idx;
        w.flg0 = 1'b0;
      end else begin
        w.idx1 = cur_idx;
        w.flg1 = 1'b0;
      end
      w.cnt = w.cnt + 2'd1;
      run_w = '0;
    end

    if (last) begin
      if (w.cnt != 2'd0 && run_w >= gap_r) w = mark_newest(w);
      w = emit_all(w);
    end

    if (w.n != 2'd0) begin
      w.res[w.n - 2'd1].run_last = 1'b1;
    end
  end

  assign push_n = in_acc ? w.n : 2'd0;

  always_comb begin
    hist_nxt    = {hist_r[1:0], v};
    seen_nxt    = (seen_r == 2'd3) ? seen_r : seen_r + 2'd1;
    run_nxt     = run_w;
    pflg_nxt    = {w.flg1, w.flg0};
    row_cnt_nxt = (row_ext == 32'(MAX_ROWS - 1)) ? '0 : row_cnt_r + CntW'(1);
    if (last) begin
      hist_nxt    = '0;
      seen_nxt    = '0;
      run_nxt     = '0;
      pflg_nxt    = '0;
      row_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r     <= GapW'(3);
      row_cnt_r <= '0;
      run_r     <= '0;
      hist_r    <= '0;
      seen_r    <= '0;
      pflg_r    <= '0;
      pcnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        gap_r <= cfg_wdata;
      end
      if (in_acc) begin
        row_cnt_r <= row_cnt_nxt;
        run_r     <= run_nxt;
        hist_r    <= hist_nxt;
        seen_r    <= seen_nxt;
        pflg_r    <= pflg_nxt;
        pcnt_r    <= last ? 2'd0 : w.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pidx_r[0] <= w.idx0;
      pidx_r[1] <= w.idx1;
    end
  end

  // Output queue: up to three writes per beat; one read per unstalled cycle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (2'(k) < push_n) begin
        oq_mem[oq_wr_r + OqAw'(k)] <= w.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_r + OqAw'(push_n);
      if (out_acc) begin
        oq_rd_r <= oq_rd_r + OqAw'(1);
      end
      oq_cnt_r <= oq_cnt_r + OqCw'(push_n) - OqCw'(out_acc);
    end
  end

  assign in_stall  = oq_cnt_r > OqCw'(OqDepth - MaxRes);
  assign out_valid = oq_cnt_r != '0;
  assign out_data  = oq_mem[oq_rd_r];

`ifndef SYNTH
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= OqCw'(OqDepth))
    else $error("output queue count exceeds its depth");

  a_row_answered: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (!in_data.sample_valid || in_data.series_last) |-> w.n != 2'd0)
    else $error("invalid or final input beat produced no result");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r != 2'd3)
    else $error("more than two rows held");

  a_series_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.series_last |=> pcnt_r == 2'd0 && row_cnt_r == '0)
    else $error("series end did not flush held rows");

  a_valid_row_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.sample_valid && !in_data.series_last |=> pcnt_r != 2'd0)
    else $error("valid row was not held");
`endif

endmodule

>>> sim/gap_marginal_sample_flagger_top_test.sv
`timescale 1ns / 1ps

module gap_marginal_sample_flagger_top_test;
  import gmsf_pkg::*;

  localparam int QuietLimit = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  gap_marginal_sample_flagger_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Flagger state as the block should hold it.
  logic [15:0] gap_win = 16'd3;
  logic [15:0] next_row;
  logic [15:0] miss_run;
  logic [2:0]  hist3;
  int          rows_seen;
  logic [15:0] held_idx [2];
  logic        held_flg [2];
  int          held_cnt;

  out_beat_t step_rows [$];
  out_beat_t expected_rows [$];
  int        fail_cnt = 0;
  bit        idle_on = 1'b1;
  int        stall_left = 0;
  int        quiet_cycles = 0;
  int        rows_sent = 0;

  function automatic void clear_series();
    next_row  = '0;
    miss_run  = '0;
    hist3     = '0;
    rows_seen = 0;
    held_cnt  = 0;
    held_flg[0] = 1'b0;
    held_flg[1] = 1'b0;
  endfunction

  function automatic void queue_row(logic [15:0] idx, logic flg);
    if (step_rows.size() < MaxRes) begin
      step_rows.push_back(out_beat_t'{row_index: idx, marginal_flag: flg, run_last: 1'b0});
    end
  endfunction

  function automatic void release_oldest();
    if (held_cnt > 0) begin
      queue_row(held_idx[0], held_flg[0]);
      held_idx[0] = held_idx[1];
      held_flg[0] = held_flg[1];
      held_cnt--;
    end
  endfunction

  function automatic void release_held();
    while (held_cnt > 0) release_oldest();
  endfunction

  function automatic void flag_newest_held();
    if (held_cnt > 0) held_flg[held_cnt-1] = 1'b1;
  endfunction

  // Decides the rows that one accepted beat settles and queues their results.
  function automatic void predict_flags(logic v, logic last);
    logic [15:0] idx;
    logic p1, p2, p3;
    idx = next_row;
    p1 = hist3[0];
    p2 = hist3[1];
    p3 = hist3[2];
    step_rows.delete();
    if (!v) begin
      if (p1) begin
        if (!p2) begin
          // A lone valid row just closed; it needs a neighbor on its left.
          if (rows_seen >= 2) begin
            flag_newest_held();
            release_held();
          end
        end else if (!p3) begin
          if (rows_seen >= 3) begin
            if (held_cnt > 0) held_flg[0] = 1'b1;
            if (held_cnt > 1) held_flg[1] = 1'b1;
            release_held();
          end else if (held_cnt > 1) begin
            release_oldest();
          end
        end
        miss_run = 16'd1;
      end else if (miss_run != 16'hFFFF) begin
        miss_run++;
      end
      queue_row(idx, 1'b0);
      if (held_cnt > 0 && miss_run >= gap_win) begin
        flag_newest_held();
        release_held();
      end
    end else begin
      if (!p1) begin
        if (held_cnt > 0) begin
          if (miss_run >= gap_win) flag_newest_held();
          release_held();
        end
      end else begin
        if (gap_win == 16'd0) flag_newest_held();
        if (p2) release_held();
      end
      if (held_cnt >= 2) release_oldest();
      held_idx[held_cnt] = idx;
      held_flg[held_cnt] = 1'b0;
      held_cnt++;
      miss_run = '0;
    end
    hist3 = {hist3[1:0], v};
    if (rows_seen < 3) rows_seen++;
    next_row++;
    if (last) begin
      if (held_cnt > 0 && miss_run >= gap_win) flag_newest_held();
      release_held();
      clear_series();
    end
    if (step_rows.size() > 0) step_rows[step_rows.size()-1].run_last = 1'b1;
    foreach (step_rows[i]) expected_rows.push_back(step_rows[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stall, then compare each beat with the oldest expectation.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        $error("row_index %0d arrived with no result pending", out_data.row_index);
        fail_cnt++;
      end else begin
        want = expected_rows.pop_front();
        if (out_data.row_index !== want.row_index) begin
          $error("row_index expected %0d actual %0d", want.row_index, out_data.row_index);
          fail_cnt++;
        end
        if (out_data.marginal_flag !== want.marginal_flag) begin
          $error("marginal_flag expected %0d actual %0d (row %0d)",
                 want.marginal_flag, out_data.marginal_flag, want.row_index);
          fail_cnt++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last expected %0d actual %0d (row %0d)",
                 want.run_last, out_data.run_last, want.row_index);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_row(input logic v, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= in_beat_t'{sample_valid: v, series_last: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_flags(v, last);
    rows_sent++;
  endtask

  task automatic send_series(input bit pat [$]);
    foreach (pat[i]) send_row(pat[i], i == pat.size() - 1);
  endtask

  task automatic send_pattern(input string s);
    bit pat [$];
    for (int i = 0; i < s.len(); i++) pat.push_back(s[i] == "1");
    send_series(pat);
  endtask

  // Stops sending and lets every expected result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gap_window(input logic [15:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gap_win = value;
  endtask

  // Reset value of the window, edge rows, runs from row 0 and to the series end.
  task automatic test_directed_edges();
    send_pattern("1000");
    send_pattern("0001");
    send_pattern("1");
    send_pattern("0");
    send_pattern("0101100011");
    // With a zero window every valid row must come out flagged.
    write_gap_window(16'd0);
    send_pattern("01101");
  endtask

  task automatic send_random_series();
    bit pat [$];
    int vrun;
    int cap;
    int blocks;
    if ($urandom_range(0, 9) < 7) begin
      // Alternating runs sized around the window, mostly lone rows and pairs.
      cap = (gap_win == 16'd0) ? 2 : (gap_win > 16'd8 ? 8 : int'(gap_win));
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) pat.push_back(1'b0);
      blocks = $urandom_range(1, 4);
      for (int b = 0; b < blocks; b++) begin
        vrun = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 2) : $urandom_range(3, 5);
        repeat (vrun) pat.push_back(1'b1);
        if (b < blocks - 1 || $urandom_range(0, 2) != 0)
          repeat ($urandom_range(1, cap + 1)) pat.push_back(1'b0);
      end
    end else begin
      repeat ($urandom_range(1, 12)) pat.push_back(1'($urandom_range(0, 1)));
    end
    send_series(pat);
  endtask

  task automatic test_random_windows();
    logic [15:0] windows [6] = '{16'd1, 16'd3, 16'd2, 16'hFFFF, 16'd0, 16'd5};
    int sent;
    foreach (windows[w]) begin
      write_gap_window(windows[w]);
      idle_on = (w != 2);
      sent = rows_sent;
      while (rows_sent - sent < 45) send_random_series();
    end
    idle_on = 1'b1;
  endtask

  // A long invalid run that stays below the widest window marks nothing.
  task automatic test_long_series();
    write_gap_window(16'hFFFF);
    idle_on = 1'b0;
    send_row(1'b1, 1'b0);
    send_row(1'b1, 1'b0);
    repeat (20) send_row(1'b0, 1'b0);
    send_row(1'b1, 1'b1);
    idle_on = 1'b1;
  endtask

  initial begin
    clear_series();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_windows();
    test_long_series();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> gap_marginal_sample_flagger_top.f
rtl/gmsf_pkg.sv
rtl/gap_marginal_sample_flagger_top.sv
sim/gap_marginal_sample_flagger_top_test.sv
